// ----- sv/psbrb_pkg.sv -----
package psbrb_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    localparam int MAC_W = 48;
    localparam int COUNT_W = 17;
    localparam int TIME_W = 32;
    localparam int LIMIT_W = 16;
    localparam int OP_W = 2;
    localparam int ACT_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // request opcodes
    localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // result actions
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BLOCK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNBLOCK = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FULL = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SECONDS = 2'd2;

    localparam logic ENABLE_RST = 1'b1;
    localparam logic [LIMIT_W-1:0] RATE_LIMIT_RST = 16'd100;
    localparam logic [LIMIT_W-1:0] BLOCK_SECONDS_RST = 16'd60;

    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [COUNT_W-1:0] count;
        logic blocked;
        logic [TIME_W-1:0] release_time;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_FIN
    } state_t;

endpackage

// ----- sv/psbrb_req_if.sv -----
interface psbrb_req_if;
    logic valid;
    logic ready;
    logic [psbrb_pkg::OP_W-1:0] op;
    logic [psbrb_pkg::MAC_W-1:0] src_mac;

    modport source (output valid, output op, output src_mac, input ready);
    modport sink (input valid, input op, input src_mac, output ready);
endinterface

// ----- sv/psbrb_res_if.sv -----
interface psbrb_res_if;
    logic valid;
    logic ready;
    logic [psbrb_pkg::ACT_W-1:0] action;
    logic [psbrb_pkg::MAC_W-1:0] mac;
    logic last;

    modport source (output valid, output action, output mac, output last, input ready);
    modport sink (input valid, input action, input mac, input last, output ready);
endinterface

// ----- sv/psbrb_cfg_if.sv -----
interface psbrb_cfg_if;
    logic valid;
    logic ready;
    logic [psbrb_pkg::CFG_IDX_W-1:0] index;
    logic [psbrb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/psbrb_ram.sv -----
module psbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- sv/per_source_broadcast_rate_blocker_core.sv -----
// sequence: a frame, tick or flush request walks every entry, reading then evaluating each,
//   then a finishing state leaves the final result in the output register; a disabled
//   frame or an unused opcode goes straight to the finishing state
// requests: a new one is accepted only in idle, after the read/evaluate walk over the
//   single-port table memory and any output stall of the one before
// reset: clears the sequencer, valid bits, seconds counter and output valid flag, loads the
//   configuration defaults; the table memory is not cleared (valid bits cover it)
module per_source_broadcast_rate_blocker_core #(
    parameter int TABLE_ENTRIES = psbrb_pkg::TABLE_ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    psbrb_req_if.sink req,
    psbrb_res_if.source res,
    psbrb_cfg_if.sink cfg
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int ENTRY_W = $bits(psbrb_pkg::entry_t);
    localparam int MAC_W = psbrb_pkg::MAC_W;
    localparam int COUNT_W = psbrb_pkg::COUNT_W;
    localparam int TIME_W = psbrb_pkg::TIME_W;
    localparam int LIMIT_W = psbrb_pkg::LIMIT_W;
    localparam int NRES_W = psbrb_pkg::NRES_W;

    // sequencer and control state
    psbrb_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [psbrb_pkg::OP_W-1:0] op_reg, op_next;
    logic [TIME_W-1:0] seconds_reg, seconds_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [NRES_W-1:0] nres_reg, nres_next;
    logic hold_valid_reg, hold_valid_next;
    logic found_reg, found_next;
    logic free_found_reg, free_found_next;
    logic out_valid_reg, out_valid_next;

    // configuration
    logic enable_reg, enable_next;
    logic [LIMIT_W-1:0] rate_limit_reg, rate_limit_next;
    logic [LIMIT_W-1:0] block_seconds_reg, block_seconds_next;

    // payload registers
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [MAC_W-1:0] hold_mac_reg, hold_mac_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic blk_reg, blk_next;
    logic [psbrb_pkg::ACT_W-1:0] out_action_reg, out_action_next;
    logic [MAC_W-1:0] out_mac_reg, out_mac_next;
    logic out_last_reg, out_last_next;

    // table memory
    logic ram_we;
    logic ram_re;
    logic [IDX_W-1:0] ram_addr;
    psbrb_pkg::entry_t ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    psbrb_pkg::entry_t rd_entry;

    // helpers
    logic req_fire;
    logic cfg_fire;
    logic out_free;
    logic walk_op;
    logic cur_valid;
    logic [TIME_W-1:0] age;
    logic expired;
    logic room;
    logic ev_unblock;
    logic ev_release;
    logic ev_stall;
    logic fin_fire;
    logic [COUNT_W-1:0] new_count;
    logic over;
    logic fin_write;
    logic [psbrb_pkg::ACT_W-1:0] fin_action;
    logic [MAC_W-1:0] fin_mac;

    psbrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_entry = psbrb_pkg::entry_t'(ram_rdata);

    // handshakes; only one request is in flight, so the table walk owns the memory
    assign req.ready = (state_reg == psbrb_pkg::S_IDLE);
    assign req_fire = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || res.ready;

    assign res.valid = out_valid_reg;
    assign res.action = out_action_reg;
    assign res.mac = out_mac_reg;
    assign res.last = out_last_reg;

    // per-entry evaluation during the walk
    assign walk_op = (op_reg == psbrb_pkg::OP_TICK) || (op_reg == psbrb_pkg::OP_FLUSH);
    assign cur_valid = valid_reg[idx_reg];
    // wrap-safe expiry: seconds minus release time lands in the lower half
    assign age = seconds_reg - rd_entry.release_time;
    assign expired = !age[TIME_W-1];
    assign room = (nres_reg < NRES_W'(psbrb_pkg::MAX_RESULTS));
    // a flush unblocks every blocked entry and a tick only expired ones, while results have room
    assign ev_unblock = walk_op && cur_valid && rd_entry.blocked && room
        && ((op_reg == psbrb_pkg::OP_FLUSH) || expired);
    // entries not blocked or just unblocked leave the table, other blocked ones stay
    assign ev_release = walk_op && cur_valid && (ev_unblock || !rd_entry.blocked);
    // a new unblock pushes the held one out, which needs room in the output register
    assign ev_stall = (state_reg == psbrb_pkg::S_EV) && ev_unblock && hold_valid_reg
        && !out_free;

    // frame update at the end of the walk
    always_comb
    begin
        if (!found_reg)
        begin
            new_count = COUNT_W'(1);
        end
        else if (cnt_reg == psbrb_pkg::COUNT_MAX)
        begin
            new_count = cnt_reg;
        end
        else
        begin
            new_count = cnt_reg + COUNT_W'(1);
        end
    end

    assign over = (new_count > COUNT_W'(rate_limit_reg));
    assign fin_fire = (state_reg == psbrb_pkg::S_FIN) && out_free;

    always_comb
    begin
        fin_write = 1'b0;
        fin_action = psbrb_pkg::ACT_NONE;
        fin_mac = MAC_W'(0);
        case (op_reg)
            psbrb_pkg::OP_FRAME:
            begin
                if (found_reg)
                begin
                    // blocked sources are not counted
                    if (!blk_reg)
                    begin
                        fin_write = 1'b1;
                        if (over)
                        begin
                            fin_action = psbrb_pkg::ACT_BLOCK;
                            fin_mac = mac_reg;
                        end
                    end
                end
                else if (free_found_reg)
                begin
                    fin_write = 1'b1;
                    if (over)
                    begin
                        fin_action = psbrb_pkg::ACT_BLOCK;
                        fin_mac = mac_reg;
                    end
                end
                else
                begin
                    // table full, event dropped
                    fin_action = psbrb_pkg::ACT_FULL;
                    fin_mac = mac_reg;
                end
            end
            psbrb_pkg::OP_TICK, psbrb_pkg::OP_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    fin_action = psbrb_pkg::ACT_UNBLOCK;
                    fin_mac = hold_mac_reg;
                end
            end
            default:
            begin
                fin_action = psbrb_pkg::ACT_NONE;
            end
        endcase
    end

    // memory access: reads during the walk, the single write at the finish
    assign ram_re = (state_reg == psbrb_pkg::S_RD);
    assign ram_we = fin_fire && fin_write;
    assign ram_addr = (state_reg == psbrb_pkg::S_FIN) ? (found_reg ? slot_reg : free_reg)
        : idx_reg;
    assign ram_wdata.mac = mac_reg;
    assign ram_wdata.count = new_count;
    assign ram_wdata.blocked = over;
    assign ram_wdata.release_time = seconds_reg + TIME_W'(block_seconds_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psbrb_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    if (op_next == psbrb_pkg::OP_NOP)
                    begin
                        state_next = psbrb_pkg::S_FIN;
                    end
                    else
                    begin
                        state_next = psbrb_pkg::S_RD;
                    end
                end
            end
            psbrb_pkg::S_RD:
            begin
                state_next = psbrb_pkg::S_EV;
            end
            psbrb_pkg::S_EV:
            begin
                if (!ev_stall)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = psbrb_pkg::S_FIN;
                    end
                    else
                    begin
                        state_next = psbrb_pkg::S_RD;
                    end
                end
            end
            psbrb_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = psbrb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = psbrb_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next = idx_reg;
        op_next = op_reg;
        mac_next = mac_reg;
        seconds_next = seconds_reg;
        valid_next = valid_reg;
        nres_next = nres_reg;
        hold_valid_next = hold_valid_reg;
        hold_mac_next = hold_mac_reg;
        found_next = found_reg;
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        blk_next = blk_reg;
        free_found_next = free_found_reg;
        free_next = free_reg;
        out_action_next = out_action_reg;
        out_mac_next = out_mac_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !res.ready;
        enable_next = enable_reg;
        rate_limit_next = rate_limit_reg;
        block_seconds_next = block_seconds_reg;

        // a disabled frame behaves like the unused opcode
        if (req_fire && (req.op == psbrb_pkg::OP_FRAME) && !enable_reg)
        begin
            op_next = psbrb_pkg::OP_NOP;
        end
        else if (req_fire)
        begin
            op_next = req.op;
        end

        if (req_fire)
        begin
            mac_next = req.src_mac;
            idx_next = '0;
            nres_next = '0;
            hold_valid_next = 1'b0;
            found_next = 1'b0;
            free_found_next = 1'b0;
            if (req.op == psbrb_pkg::OP_TICK)
            begin
                seconds_next = seconds_reg + TIME_W'(1);
            end
        end

        if ((state_reg == psbrb_pkg::S_EV) && !ev_stall)
        begin
            if (op_reg == psbrb_pkg::OP_FRAME)
            begin
                // first matching entry wins, lowest free slot for a new source
                if (cur_valid && !found_reg && (rd_entry.mac == mac_reg))
                begin
                    found_next = 1'b1;
                    slot_next = idx_reg;
                    cnt_next = rd_entry.count;
                    blk_next = rd_entry.blocked;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next = idx_reg;
                end
            end
            if (ev_release)
            begin
                valid_next[idx_reg] = 1'b0;
            end
            if (ev_unblock)
            begin
                nres_next = nres_reg + NRES_W'(1);
                hold_valid_next = 1'b1;
                hold_mac_next = rd_entry.mac;
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_action_next = psbrb_pkg::ACT_UNBLOCK;
                    out_mac_next = hold_mac_reg;
                    out_last_next = 1'b0;
                end
            end
            if (idx_reg != LAST_IDX)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        if (fin_fire)
        begin
            out_valid_next = 1'b1;
            out_action_next = fin_action;
            out_mac_next = fin_mac;
            out_last_next = 1'b1;
            hold_valid_next = 1'b0;
            if (fin_write && !found_reg)
            begin
                valid_next[free_reg] = 1'b1;
            end
        end

        if (cfg_fire)
        begin
            case (cfg.index)
                psbrb_pkg::CFG_ENABLE:
                begin
                    enable_next = cfg.data[0];
                end
                psbrb_pkg::CFG_RATE_LIMIT:
                begin
                    rate_limit_next = LIMIT_W'(cfg.data);
                end
                psbrb_pkg::CFG_BLOCK_SECONDS:
                begin
                    block_seconds_next = LIMIT_W'(cfg.data);
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psbrb_pkg::S_IDLE;
            idx_reg <= '0;
            op_reg <= psbrb_pkg::OP_NOP;
            seconds_reg <= '0;
            valid_reg <= '0;
            nres_reg <= '0;
            hold_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg <= psbrb_pkg::ENABLE_RST;
            rate_limit_reg <= psbrb_pkg::RATE_LIMIT_RST;
            block_seconds_reg <= psbrb_pkg::BLOCK_SECONDS_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            op_reg <= op_next;
            seconds_reg <= seconds_next;
            valid_reg <= valid_next;
            nres_reg <= nres_next;
            hold_valid_reg <= hold_valid_next;
            found_reg <= found_next;
            free_found_reg <= free_found_next;
            out_valid_reg <= out_valid_next;
            enable_reg <= enable_next;
            rate_limit_reg <= rate_limit_next;
            block_seconds_reg <= block_seconds_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mac_reg <= mac_next;
        hold_mac_reg <= hold_mac_next;
        slot_reg <= slot_next;
        free_reg <= free_next;
        cnt_reg <= cnt_next;
        blk_reg <= blk_next;
        out_action_reg <= out_action_next;
        out_mac_reg <= out_mac_next;
        out_last_reg <= out_last_next;
    end

    // no held unblock survives past the end of a request
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psbrb_pkg::S_IDLE) |-> !hold_valid_reg)
        else $error("held unblock left over in idle");

    // unblock count never passes the result cap
    a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= NRES_W'(psbrb_pkg::MAX_RESULTS))
        else $error("unblock count beyond cap");

    // the finishing cycle always leaves a final result in the output register
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> (res.valid && res.last))
        else $error("final result missing after finish");

    // every table write lands in an entry that is valid afterwards
    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_addr)])
        else $error("table write to an entry left invalid");

    // the seconds counter moves only on an accepted tick
    a_seconds_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (seconds_reg != $past(seconds_reg))
            |-> $past(req_fire && (req.op == psbrb_pkg::OP_TICK)))
        else $error("seconds counter moved without a tick");

endmodule

// ----- test/per_source_broadcast_rate_blocker_core_tb.sv -----
module per_source_broadcast_rate_blocker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENTRIES = psbrb_pkg::TABLE_ENTRIES_DEF;
    localparam int MAC_W = psbrb_pkg::MAC_W;
    localparam int ACT_W = psbrb_pkg::ACT_W;
    localparam int OP_W = psbrb_pkg::OP_W;
    localparam int LIMIT_W = psbrb_pkg::LIMIT_W;
    localparam int COUNT_W = psbrb_pkg::COUNT_W;
    localparam int TIME_W = psbrb_pkg::TIME_W;
    localparam int CFG_IDX_W = psbrb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = psbrb_pkg::CFG_DATA_W;
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    // no request, result or register write for this long means the block is hung
    localparam int WATCHDOG_LIMIT = 4000;
    // a request always ends in a result, and the block is back in idle once its last result is out
    localparam int SETTLE_CYCLES = 4;
    // one full table walk plus margin after the last result
    localparam int DRAIN_CYCLES = 2 * N_ENTRIES + 8;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int POOL_MAX = 32;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;

    // one result of the block
    typedef struct {
        logic [ACT_W-1:0] action;
        logic [MAC_W-1:0] mac;
        logic last;
    } action_t;

    // storm-control table model plus the queue of actions still owed by the block
    class action_scoreboard;
        bit enable;
        bit [LIMIT_W-1:0] rate_limit;
        bit [LIMIT_W-1:0] block_seconds;
        bit in_use[N_ENTRIES];
        bit [MAC_W-1:0] mac_tbl[N_ENTRIES];
        bit [COUNT_W-1:0] frames[N_ENTRIES];
        bit blocked[N_ENTRIES];
        bit [TIME_W-1:0] release_at[N_ENTRIES];
        bit [TIME_W-1:0] seconds;
        action_t expected_actions[$];
        int errors;

        function new();
            enable = psbrb_pkg::ENABLE_RST;
            rate_limit = psbrb_pkg::RATE_LIMIT_RST;
            block_seconds = psbrb_pkg::BLOCK_SECONDS_RST;
            foreach (in_use[i])
                in_use[i] = 1'b0;
            seconds = '0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                psbrb_pkg::CFG_ENABLE: enable = value[0];
                psbrb_pkg::CFG_RATE_LIMIT: rate_limit = value;
                psbrb_pkg::CFG_BLOCK_SECONDS: block_seconds = value;
                default: ;
            endcase
        endfunction

        // works out the actions one accepted request causes and queues them
        function void note_request(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac);
            action_t acts[$];
            int slot;
            int free_slot;
            bit [TIME_W-1:0] age;
            case (op)
                psbrb_pkg::OP_FRAME:
                    if (enable)
                    begin
                        slot = -1;
                        free_slot = -1;
                        for (int i = 0; i < N_ENTRIES; i++)
                        begin
                            if (in_use[i])
                            begin
                                if (slot < 0 && mac_tbl[i] == mac)
                                    slot = i;
                            end
                            else if (free_slot < 0)
                                free_slot = i;
                        end
                        if (slot < 0 && free_slot < 0)
                            acts.push_back('{psbrb_pkg::ACT_FULL, mac, 1'b0});
                        else
                        begin
                            if (slot < 0)
                            begin
                                slot = free_slot;
                                in_use[slot] = 1'b1;
                                mac_tbl[slot] = mac;
                                frames[slot] = '0;
                                blocked[slot] = 1'b0;
                                release_at[slot] = '0;
                            end
                            if (!blocked[slot])
                            begin
                                if (frames[slot] != psbrb_pkg::COUNT_MAX)
                                    frames[slot]++;
                                if (frames[slot] > rate_limit)
                                begin
                                    blocked[slot] = 1'b1;
                                    release_at[slot] = seconds + block_seconds;
                                    acts.push_back('{psbrb_pkg::ACT_BLOCK, mac, 1'b0});
                                end
                            end
                        end
                    end
                psbrb_pkg::OP_TICK:
                begin
                    seconds++;
                    for (int i = 0; i < N_ENTRIES; i++)
                    begin
                        if (!in_use[i])
                            continue;
                        // expired when the wrapped age is non-negative
                        age = seconds - release_at[i];
                        if (blocked[i] && acts.size() < psbrb_pkg::MAX_RESULTS
                            && !age[TIME_W-1])
                        begin
                            acts.push_back('{psbrb_pkg::ACT_UNBLOCK, mac_tbl[i], 1'b0});
                            blocked[i] = 1'b0;
                        end
                        frames[i] = '0;
                        if (!blocked[i])
                            in_use[i] = 1'b0;
                    end
                end
                psbrb_pkg::OP_FLUSH:
                    for (int i = 0; i < N_ENTRIES; i++)
                    begin
                        if (!in_use[i])
                            continue;
                        if (blocked[i])
                        begin
                            if (acts.size() >= psbrb_pkg::MAX_RESULTS)
                                continue;
                            acts.push_back('{psbrb_pkg::ACT_UNBLOCK, mac_tbl[i], 1'b0});
                            blocked[i] = 1'b0;
                        end
                        in_use[i] = 1'b0;
                    end
                default: ;
            endcase
            if (acts.size() == 0)
                acts.push_back('{psbrb_pkg::ACT_NONE, '0, 1'b0});
            acts[acts.size()-1].last = 1'b1;
            foreach (acts[k])
                expected_actions.push_back(acts[k]);
        endfunction

        function void check_action(logic [ACT_W-1:0] action, logic [MAC_W-1:0] mac, logic last);
            action_t want;
            if (expected_actions.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got action %0d mac %h last %b",
                         $time, action, mac, last);
                return;
            end
            want = expected_actions.pop_front();
            if (action !== want.action)
            begin
                errors++;
                $display("%0t: action mismatch, expected %0d, got %0d", $time, want.action, action);
            end
            if (mac !== want.mac)
            begin
                errors++;
                $display("%0t: mac mismatch, expected %h, got %h", $time, want.mac, mac);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    psbrb_req_if req_ch();
    psbrb_res_if res_ch();
    psbrb_cfg_if cfg_ch();

    action_scoreboard blocker_sb;

    int burst_left = 0;
    int stall_cycle = 0;
    int quiet_cycles = 0;

    per_source_broadcast_rate_blocker_core #(
        .TABLE_ENTRIES(N_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .res(res_ch),
        .cfg(cfg_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // result back-pressure: cycles through always-ready, light random, periodic and heavy random
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 150) % 4)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2: res_ch.ready <= ((stall_cycle % 7) >= 3);
            default: res_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // every accepted result goes against the oldest expected action
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            blocker_sb.check_action(res_ch.action, res_ch.mac, res_ch.last);
    end

    // hang detection on any handshake of the three channels
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    // valid stays up across a burst; the sender pauses only between bursts or while waiting for idle
    task automatic pause_sender(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.src_mac <= mac;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        blocker_sb.note_request(op, mac);
    endtask

    // hold requests until every owed action has come back, then let the block finish
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (blocker_sb.expected_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        blocker_sb.set_register(idx, value);
    endtask

    // writes are back to back, so valid only drops after the last one
    task automatic configure(logic en, logic [LIMIT_W-1:0] rate, logic [LIMIT_W-1:0] blk);
        write_register(psbrb_pkg::CFG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
        write_register(psbrb_pkg::CFG_RATE_LIMIT, rate);
        write_register(psbrb_pkg::CFG_BLOCK_SECONDS, blk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [MAC_W-1:0] mac_pool[POOL_MAX];
        logic [MAC_W-1:0] probe_mac;
        logic [LIMIT_W-1:0] rate;
        logic [LIMIT_W-1:0] blk;
        logic en;
        int pool_n;
        int pick;
        int k;

        blocker_sb = new();
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = psbrb_pkg::OP_FRAME;
        req_ch.src_mac = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = psbrb_pkg::CFG_ENABLE;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: lowest and highest source, unused opcode, tick freeing both
        send_request(psbrb_pkg::OP_FRAME, '0);
        send_request(psbrb_pkg::OP_FRAME, MAC_ONES);
        send_request(psbrb_pkg::OP_NOP, random_mac());
        send_request(psbrb_pkg::OP_TICK, random_mac());

        // frames are dropped while disabled
        wait_idle();
        configure(1'b0, '0, '0);
        send_request(psbrb_pkg::OP_FRAME, random_mac());

        // zero limit blocks on the first frame, zero block time releases on the next tick
        wait_idle();
        configure(1'b1, '0, '0);
        probe_mac = random_mac();
        send_request(psbrb_pkg::OP_FRAME, probe_mac);
        send_request(psbrb_pkg::OP_FRAME, probe_mac);
        send_request(psbrb_pkg::OP_TICK, random_mac());

        // fill every entry with a blocked source, overflow once, then flush them all
        for (k = 0; k < N_ENTRIES + 1; k++)
            send_request(psbrb_pkg::OP_FRAME, random_mac());
        send_request(psbrb_pkg::OP_FLUSH, random_mac());

        // random traffic over a small pool of sources so counts build up and blocks happen
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    en = 1'b1; rate = 16'd2; blk = 16'd1; pool_n = 6;
                end
                1:
                begin
                    en = 1'b1; rate = 16'd0; blk = 16'd3; pool_n = 24;
                end
                2:
                begin
                    en = 1'b1; rate = 16'hFFFF; blk = 16'hFFFF; pool_n = 10;
                end
                3:
                begin
                    en = 1'b0; rate = 16'd1; blk = 16'd0; pool_n = 8;
                end
                4:
                begin
                    en = 1'b1; rate = 16'd3; blk = 16'hFFFF; pool_n = 18;
                end
                default:
                begin
                    en = 1'b1;
                    rate = LIMIT_W'($urandom_range(0, 4));
                    blk = LIMIT_W'($urandom_range(0, 3));
                    pool_n = $urandom_range(4, 24);
                end
            endcase
            configure(en, rate, blk);
            for (k = 0; k < pool_n; k++)
                mac_pool[k] = random_mac();
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_request(psbrb_pkg::OP_FRAME, mac_pool[$urandom_range(0, pool_n - 1)]);
                else if (pick < 78)
                    send_request(psbrb_pkg::OP_FRAME, random_mac());
                else if (pick < 92)
                    send_request(psbrb_pkg::OP_TICK, random_mac());
                else if (pick < 97)
                    send_request(psbrb_pkg::OP_FLUSH, random_mac());
                else
                    send_request(psbrb_pkg::OP_NOP, random_mac());
                // now and then hold off until the block has drained
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (blocker_sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
